// ----- hdl/pacull_pkg.sv -----
// Shared types, constants and helpers for primitive assembly with near-plane cull.
`timescale 1ns / 1ps
`default_nettype none

package pacull_pkg;

  // Width of the vertex id fields on the ports
  localparam int unsigned VidW = 16;
  // Default number of vertex id bits kept in the assembly state
  localparam int unsigned VertexIdBitsDef = 16;
  // Depth of the queue between front and back
  localparam int unsigned QDepth = 4;

  typedef enum logic [0:0] {
    OpVertex = 1'b0,
    OpEnd    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ModePoints   = 3'd0,
    ModeLines    = 3'd1,
    ModeStrip    = 3'd2,
    ModeLoop     = 3'd3,
    ModeTris     = 3'd4,
    ModeTriStrip = 3'd5,
    ModeFan      = 3'd6,
    ModeQuads    = 3'd7
  } prim_mode_e;

  typedef enum logic [1:0] {
    KindPoint = 2'd0,
    KindLine  = 2'd1,
    KindTri   = 2'd2
  } prim_kind_e;

  typedef enum logic [1:0] {
    ClsDraw    = 2'd0,
    ClsClip    = 2'd1,
    ClsDiscard = 2'd2
  } clip_class_e;

  // One queue entry: a single primitive, or a quad split into (a,b,c) and (a,c,d)
  typedef struct packed {
    prim_kind_e        kind;
    logic              pair;
    logic [VidW-1:0]   va;
    logic [VidW-1:0]   vb;
    logic [VidW-1:0]   vc;
    logic [VidW-1:0]   vd;
    clip_class_e       cls0;
    clip_class_e       cls1;
  } prim_job_t;

  function automatic clip_class_e clip_of(input logic [1:0] fronts, input logic [1:0] total);
    clip_class_e cls;
    if (fronts == total) begin
      cls = ClsDraw;
    end else if (fronts == 2'd0) begin
      cls = ClsDiscard;
    end else begin
      cls = ClsClip;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pacull_front.sv -----
// Front part: takes vertex words, tracks batch state and builds primitive jobs.
`timescale 1ns / 1ps
`default_nettype none

module pacull_front #(
  parameter int unsigned VERTEX_ID_BITS = pacull_pkg::VertexIdBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [2:0]                  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        operation_i,
  input  wire logic [pacull_pkg::VidW-1:0] vertex_id_i,
  input  wire logic                        in_front_i,
  input  wire logic                        q_full_i,
  output logic                             in_stall_o,
  output logic                             push_o,
  output pacull_pkg::prim_job_t            job_o
);

  localparam int unsigned IdW =
    (VERTEX_ID_BITS < pacull_pkg::VidW) ? VERTEX_ID_BITS : pacull_pkg::VidW;

  pacull_pkg::prim_mode_e mode_q, mode_d;
  logic [IdW-1:0] first_id_q, first_id_d;
  logic [IdW-1:0] prev_id_q, prev_id_d;
  logic [IdW-1:0] older_id_q, older_id_d;
  logic           first_fr_q, first_fr_d;
  logic           prev_fr_q, prev_fr_d;
  logic           older_fr_q, older_fr_d;
  logic [1:0]     phase_q, phase_d;
  logic [1:0]     seen_q, seen_d;
  logic           parity_q, parity_d;

  logic           accept;
  logic [IdW-1:0] nv_id;
  logic           nv_fr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign nv_id      = vertex_id_i[IdW-1:0];
  assign nv_fr      = in_front_i;

  always_comb begin
    mode_d     = mode_q;
    first_id_d = first_id_q;
    prev_id_d  = prev_id_q;
    older_id_d = older_id_q;
    first_fr_d = first_fr_q;
    prev_fr_d  = prev_fr_q;
    older_fr_d = older_fr_q;
    phase_d    = phase_q;
    seen_d     = seen_q;
    parity_d   = parity_q;
    push_o     = 1'b0;
    job_o      = '0;
    job_o.kind = pacull_pkg::KindTri;

    if (accept) begin
      if (operation_i == pacull_pkg::OpEnd) begin
        if (mode_q == pacull_pkg::ModeLoop && seen_q == 2'd3) begin
          push_o     = 1'b1;
          job_o.kind = pacull_pkg::KindLine;
          job_o.va   = pacull_pkg::VidW'(prev_id_q);
          job_o.vb   = pacull_pkg::VidW'(first_id_q);
          job_o.cls0 = pacull_pkg::clip_of(2'(prev_fr_q) + 2'(first_fr_q), 2'd2);
        end
        first_id_d = '0;
        prev_id_d  = '0;
        older_id_d = '0;
        first_fr_d = 1'b0;
        prev_fr_d  = 1'b0;
        older_fr_d = 1'b0;
        phase_d    = '0;
        seen_d     = '0;
        parity_d   = 1'b0;
      end else begin
        if (seen_q == 2'd0) begin
          first_id_d = nv_id;
          first_fr_d = nv_fr;
        end
        case (mode_q)
          pacull_pkg::ModePoints: begin
            push_o     = 1'b1;
            job_o.kind = pacull_pkg::KindPoint;
            job_o.va   = pacull_pkg::VidW'(nv_id);
            job_o.cls0 = pacull_pkg::clip_of(2'(nv_fr), 2'd1);
          end
          pacull_pkg::ModeLines: begin
            if (phase_q == 2'd1) begin
              push_o     = 1'b1;
              job_o.kind = pacull_pkg::KindLine;
              job_o.va   = pacull_pkg::VidW'(prev_id_q);
              job_o.vb   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(2'(prev_fr_q) + 2'(nv_fr), 2'd2);
            end
            phase_d = (phase_q >= 2'd1) ? 2'd0 : phase_q + 2'd1;
          end
          pacull_pkg::ModeStrip, pacull_pkg::ModeLoop: begin
            if (seen_q >= 2'd1) begin
              push_o     = 1'b1;
              job_o.kind = pacull_pkg::KindLine;
              job_o.va   = pacull_pkg::VidW'(prev_id_q);
              job_o.vb   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(2'(prev_fr_q) + 2'(nv_fr), 2'd2);
            end
          end
          pacull_pkg::ModeTris: begin
            if (phase_q == 2'd2) begin
              push_o     = 1'b1;
              job_o.va   = pacull_pkg::VidW'(older_id_q);
              job_o.vb   = pacull_pkg::VidW'(prev_id_q);
              job_o.vc   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(
                2'(older_fr_q) + 2'(prev_fr_q) + 2'(nv_fr), 2'd3);
            end
            phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
          end
          pacull_pkg::ModeTriStrip: begin
            if (seen_q >= 2'd2) begin
              push_o     = 1'b1;
              // odd triangles swap their first two corners
              job_o.va   = pacull_pkg::VidW'(parity_q ? prev_id_q : older_id_q);
              job_o.vb   = pacull_pkg::VidW'(parity_q ? older_id_q : prev_id_q);
              job_o.vc   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(
                2'(older_fr_q) + 2'(prev_fr_q) + 2'(nv_fr), 2'd3);
              parity_d   = !parity_q;
            end
          end
          pacull_pkg::ModeFan: begin
            if (seen_q >= 2'd2) begin
              push_o     = 1'b1;
              job_o.va   = pacull_pkg::VidW'(first_id_q);
              job_o.vb   = pacull_pkg::VidW'(prev_id_q);
              job_o.vc   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(
                2'(first_fr_q) + 2'(prev_fr_q) + 2'(nv_fr), 2'd3);
            end
          end
          default: begin
            // quads: corner 0 latched at group start, two triangles on corner 3
            if (phase_q == 2'd0) begin
              first_id_d = nv_id;
              first_fr_d = nv_fr;
            end
            if (phase_q == 2'd3) begin
              push_o     = 1'b1;
              job_o.pair = 1'b1;
              job_o.va   = pacull_pkg::VidW'(first_id_q);
              job_o.vb   = pacull_pkg::VidW'(older_id_q);
              job_o.vc   = pacull_pkg::VidW'(prev_id_q);
              job_o.vd   = pacull_pkg::VidW'(nv_id);
              job_o.cls0 = pacull_pkg::clip_of(
                2'(first_fr_q) + 2'(older_fr_q) + 2'(prev_fr_q), 2'd3);
              job_o.cls1 = pacull_pkg::clip_of(
                2'(first_fr_q) + 2'(prev_fr_q) + 2'(nv_fr), 2'd3);
            end
            phase_d = phase_q + 2'd1;
          end
        endcase
        older_id_d = prev_id_q;
        older_fr_d = prev_fr_q;
        prev_id_d  = nv_id;
        prev_fr_d  = nv_fr;
        if (seen_q != 2'd3) begin
          seen_d = seen_q + 2'd1;
        end
      end
    end

    // mode write starts a fresh batch
    if (cfg_we_i) begin
      mode_d     = pacull_pkg::prim_mode_e'(cfg_wdata_i);
      first_id_d = '0;
      prev_id_d  = '0;
      older_id_d = '0;
      first_fr_d = 1'b0;
      prev_fr_d  = 1'b0;
      older_fr_d = 1'b0;
      phase_d    = '0;
      seen_d     = '0;
      parity_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pacull_pkg::ModePoints;
      first_id_q <= '0;
      prev_id_q  <= '0;
      older_id_q <= '0;
      first_fr_q <= 1'b0;
      prev_fr_q  <= 1'b0;
      older_fr_q <= 1'b0;
      phase_q    <= '0;
      seen_q     <= '0;
      parity_q   <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      first_id_q <= first_id_d;
      prev_id_q  <= prev_id_d;
      older_id_q <= older_id_d;
      first_fr_q <= first_fr_d;
      prev_fr_q  <= prev_fr_d;
      older_fr_q <= older_fr_d;
      phase_q    <= phase_d;
      seen_q     <= seen_d;
      parity_q   <= parity_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pacull_queue.sv -----
// Short job queue between the assembly front and the output back.
`timescale 1ns / 1ps
`default_nettype none

module pacull_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire pacull_pkg::prim_job_t job_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       valid_o,
  output pacull_pkg::prim_job_t      job_o
);

  localparam int unsigned PtrW = $clog2(pacull_pkg::QDepth);
  localparam int unsigned CntW = PtrW + 1;

  pacull_pkg::prim_job_t entry_q [pacull_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(pacull_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pacull_back.sv -----
// Back part: turns queued jobs into result words, splitting quads in two.
`timescale 1ns / 1ps
`default_nettype none

module pacull_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  input  wire pacull_pkg::prim_job_t       job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       prim_kind_o,
  output logic [pacull_pkg::VidW-1:0]      vert_a_o,
  output logic [pacull_pkg::VidW-1:0]      vert_b_o,
  output logic [pacull_pkg::VidW-1:0]      vert_c_o,
  output logic [1:0]                       clip_class_o,
  output logic                             last_o
);

  // high while the second triangle of a quad is on the port
  logic half_q, half_d;
  logic take;

  assign out_valid_o  = job_valid_i;
  assign take         = job_valid_i && !out_stall_i;
  assign last_o       = !job_i.pair || half_q;
  assign pop_o        = take && last_o;
  assign prim_kind_o  = job_i.kind;
  assign vert_a_o     = job_i.va;
  assign vert_b_o     = half_q ? job_i.vc : job_i.vb;
  assign vert_c_o     = half_q ? job_i.vd : job_i.vc;
  assign clip_class_o = half_q ? job_i.cls1 : job_i.cls0;

  always_comb begin
    half_d = half_q;
    if (take) begin
      half_d = job_i.pair && !half_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else begin
      half_q <= half_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/primitive_assembly_near_cull.sv -----
// Top level: primitive assembly with near-plane classification.
//
//  channel   dir  handshake                 word
//  cfg       in   cfg_we_i                  cfg_wdata_i (primitive mode)
//  in        in   in_valid_i / in_stall_o   operation, vertex_id, in_front
//  out       out  out_valid_o / out_stall_i prim_kind, vert_a/b/c, clip_class, last
//
// One input word per cycle while in_stall_o is low; the job queue registers each job.
// The back emits one word per unstalled cycle; a quad gives two words on its fourth vertex.
// A 4-entry job queue between front and back sets how long the output may stall
// before in_stall_o rises (queue full).
// Reset: mode points, batch state cleared, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module primitive_assembly_near_cull #(
  parameter int unsigned VERTEX_ID_BITS = pacull_pkg::VertexIdBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [2:0]                  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [pacull_pkg::VidW-1:0] vertex_id_i,
  input  wire logic                        in_front_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       prim_kind_o,
  output logic [pacull_pkg::VidW-1:0]      vert_a_o,
  output logic [pacull_pkg::VidW-1:0]      vert_b_o,
  output logic [pacull_pkg::VidW-1:0]      vert_c_o,
  output logic [1:0]                       clip_class_o,
  output logic                             last_o
);

  pacull_pkg::prim_job_t push_job;
  pacull_pkg::prim_job_t head_job;
  logic                  push;
  logic                  q_full;
  logic                  head_valid;
  logic                  pop;

  pacull_front #(
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .vertex_id_i (vertex_id_i),
    .in_front_i  (in_front_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .job_o       (push_job)
  );

  pacull_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  pacull_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (head_valid),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .prim_kind_o  (prim_kind_o),
    .vert_a_o     (vert_a_o),
    .vert_b_o     (vert_b_o),
    .vert_c_o     (vert_c_o),
    .clip_class_o (clip_class_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- hdl/pacull_checker.sv -----
// Port-level checks for the primitive assembly block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pacull_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [1:0]                  prim_kind_o,
  input wire logic [pacull_pkg::VidW-1:0] vert_a_o,
  input wire logic [pacull_pkg::VidW-1:0] vert_b_o,
  input wire logic [pacull_pkg::VidW-1:0] vert_c_o,
  input wire logic [1:0]                  clip_class_o,
  input wire logic                        last_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(prim_kind_o)
      && $stable(vert_a_o) && $stable(vert_b_o) && $stable(vert_c_o)
      && $stable(clip_class_o) && $stable(last_o))
    else $error("stalled result word changed");

  // unused corners read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prim_kind_o != pacull_pkg::KindTri |-> vert_c_o == '0
      && (prim_kind_o != pacull_pkg::KindPoint || vert_b_o == '0))
    else $error("unused vertex field not zero");

  // only quads give two words, and those are triangles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prim_kind_o != pacull_pkg::KindTri |-> last_o)
    else $error("point or line word without last");

  // kind and class codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prim_kind_o == pacull_pkg::KindPoint
      || prim_kind_o == pacull_pkg::KindLine || prim_kind_o == pacull_pkg::KindTri)
      && (clip_class_o == pacull_pkg::ClsDraw || clip_class_o == pacull_pkg::ClsClip
      || clip_class_o == pacull_pkg::ClsDiscard))
    else $error("result code out of range");

endmodule

bind primitive_assembly_near_cull pacull_checker u_pacull_checker (.*);

`default_nettype wire
